/* src/dnle_pkg.sv */
// shared types and constants for the dns name label encoder
package dnle_pkg;

    localparam int LEN_W         = 6;
    localparam int LABEL_MAX_DEF = 62;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one queued command: a buffer write or a label/terminator burst
    typedef struct packed {
        logic             is_emit;
        logic [7:0]       char_byte;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             term;
        logic             has_label;
    } t_cmd;

endpackage

/* src/dnle_char_if.sv */
// input channel: one name character or an end-of-name mark per item
interface dnle_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_name;

    modport source (output valid, output char_byte, output end_of_name, input ready);
    modport sink   (input valid, input char_byte, input end_of_name, output ready);
endinterface

/* src/dnle_byte_if.sv */
// output channel: one wire-format byte per item
interface dnle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       label_too_long;

    modport source (output valid, output out_byte, output last_of_run,
                    output label_too_long, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input label_too_long, output ready);
endinterface

/* src/dnle_front.sv */
// front end: accepts characters, tracks label length and overflow, issues commands
module dnle_front
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnle_char_if.sink   i_char,
    output t_cmd        o_cmd,
    output logic        o_push,
    input  logic        i_full
);

    logic [LEN_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             accept;
    logic             is_char;
    logic             room;

    assign i_char.ready = !i_full;
    assign accept  = i_char.valid && i_char.ready;
    assign is_char = !i_char.end_of_name && (i_char.char_byte != DOT_CHAR);
    assign room    = r_count < LEN_W'(LABEL_MAX);

    // overflowing characters are dropped without a command
    assign o_push = accept && (!is_char || room);

    always_comb begin
        o_cmd.is_emit   = !is_char;
        o_cmd.char_byte = i_char.char_byte;
        o_cmd.len       = r_count;
        o_cmd.ovf       = r_ovf;
        o_cmd.term      = i_char.end_of_name;
        o_cmd.has_label = !i_char.end_of_name || (r_count != '0) || r_ovf;
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (accept) begin
            if (is_char) begin
                if (room) begin
                    n_count = r_count + LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end else begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

/* src/dnle_queue.sv */
// short command queue between front and back ends
module dnle_queue
    import dnle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* src/dnle_back.sv */
// back end: label buffer, burst sequencer and output register
module dnle_back
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    dnle_byte_if.source o_byte
);

    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DATA = 2'd1;
    localparam logic [1:0] ST_TERM = 2'd2;

    logic [7:0]       r_store [LABEL_MAX];
    logic [7:0]       r_mem_q;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_idx, n_idx;

    // stage one holds the generated byte, or marks that it comes from the buffer read
    logic             r_s1_v;
    logic [7:0]       r_s1_byte;
    logic             r_s1_last;
    logic             r_s1_err;
    logic             r_s1_mem;

    logic             r_out_v;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_err;

    logic             out_move;
    logic             adv;
    logic             gen;
    logic [7:0]       g_byte;
    logic             g_last;
    logic             g_mem;
    logic             rd_en;
    logic             wr_en;

    assign out_move = r_s1_v && (!r_out_v || o_byte.ready);
    assign adv      = !r_s1_v || out_move;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        gen     = 1'b0;
        g_byte  = '0;
        g_last  = 1'b0;
        g_mem   = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_cmd.is_emit) begin
                        wr_en = 1'b1;
                        o_pop = 1'b1;
                    end else if (adv) begin
                        gen = 1'b1;
                        if (i_cmd.has_label) begin
                            g_byte = 8'(i_cmd.len);
                            if (i_cmd.len != '0) begin
                                n_state = ST_DATA;
                                n_idx   = '0;
                            end else if (i_cmd.term) begin
                                n_state = ST_TERM;
                            end else begin
                                g_last = 1'b1;
                                o_pop  = 1'b1;
                            end
                        end else begin
                            // lone terminator
                            g_last = 1'b1;
                            o_pop  = 1'b1;
                        end
                    end
                end
            end
            ST_DATA: begin
                if (adv) begin
                    gen   = 1'b1;
                    g_mem = 1'b1;
                    rd_en = 1'b1;
                    n_idx = r_idx + LEN_W'(1);
                    if (r_idx == i_cmd.len - LEN_W'(1)) begin
                        if (i_cmd.term) begin
                            n_state = ST_TERM;
                        end else begin
                            g_last  = 1'b1;
                            o_pop   = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_TERM: begin
                if (adv) begin
                    gen     = 1'b1;
                    g_last  = 1'b1;
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[i_cmd.len[AW-1:0]] <= i_cmd.char_byte;
        end
        if (rd_en) begin
            r_mem_q <= r_store[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && gen) begin
            r_s1_byte <= g_byte;
            r_s1_last <= g_last;
            r_s1_err  <= i_cmd.ovf;
            r_s1_mem  <= g_mem;
        end
        if (out_move) begin
            r_out_byte <= r_s1_mem ? r_mem_q : r_s1_byte;
            r_out_last <= r_s1_last;
            r_out_err  <= r_s1_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (adv) begin
                r_s1_v <= gen;
            end
            if (out_move) begin
                r_out_v <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_byte.valid          = r_out_v;
    assign o_byte.out_byte       = r_out_byte;
    assign o_byte.last_of_run    = r_out_last;
    assign o_byte.label_too_long = r_out_err;

endmodule

/* src/dns_name_label_encoder_top.sv */
// Encodes a dotted host name, one character per item, into DNS wire format: a length
// byte and the label bytes per label, then a zero byte. The front end takes one item
// per cycle while the four-entry command queue has room; the back end writes each stored
// character into its label buffer while idle and reads the buffer back while it sends a
// label's bytes, so it takes no new command from the queue during a burst, and its output
// can be held by back-pressure. Characters beyond LABEL_MAX are dropped and the whole
// burst of that label is flagged with label_too_long. The label buffer needs no clearing
// after reset.
module dns_name_label_encoder_top
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnle_char_if.sink   i_char,
    dnle_byte_if.source o_byte
);

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic full;
    logic head_valid;
    logic pop;

    dnle_front #(
        .LABEL_MAX (LABEL_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .o_cmd   (push_cmd),
        .o_push  (push),
        .i_full  (full)
    );

    dnle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    dnle_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule
